// ----- src/base64_stream_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream encoder
// Concurrent checks clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_ASSERT_SVH
`define BASE64_STREAM_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("base64 encoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("base64 encoder check failed");

`endif

// ----- src/b64e_pkg.sv -----
// ----------------------------------------------------------------------------
// b64e_pkg
// Beat types, job format and the character table of the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_beat_t;

  // One output position of a job: a six-bit code or a pad character.
  typedef struct packed {
    logic       pad;
    logic [5:0] code;
  } slot_t;

  // Everything one source byte causes: up to four characters.
  typedef struct packed {
    slot_t [3:0] slot;
    logic  [1:0] last_idx;
    logic        eom;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] carry;
  } front_stat_t;

  localparam int unsigned QueueDepth = 2;

  localparam logic [6:0] CHAR_UPPER_BASE = 7'd65;  // 'A'
  localparam logic [6:0] CHAR_LOWER_BASE = 7'd71;  // 'a' - 26
  localparam logic [6:0] CHAR_DIGIT_OFFS = 7'd4;   // 52 - '0'
  localparam logic [6:0] CHAR_PLUS       = 7'd43;  // '+'
  localparam logic [6:0] CHAR_SLASH      = 7'd47;  // '/'
  localparam logic [6:0] CHAR_PAD        = 7'd61;  // '='

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [6:0] w;
    w = {1'b0, v};
    if (v <= 6'd25)      return w + CHAR_UPPER_BASE;
    else if (v <= 6'd51) return w + CHAR_LOWER_BASE;
    else if (v <= 6'd61) return w - CHAR_DIGIT_OFFS;
    else if (v == 6'd62) return CHAR_PLUS;
    else                 return CHAR_SLASH;
  endfunction

endpackage

// ----- src/b64e_front.sv -----
// ----------------------------------------------------------------------------
// b64e_front
// Takes source bytes, tracks the group position and builds character jobs.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  b64e_pkg::in_beat_t   byte_beat,
  input  logic                 queue_full,
  output logic                 push,
  output b64e_pkg::job_t       job,
  output b64e_pkg::front_stat_t stat
);
  import b64e_pkg::*;

  logic [1:0] phase;
  logic [3:0] carry;
  logic [1:0] phase_next;
  logic [3:0] carry_next;
  logic [7:0] b;

  assign b          = byte_beat.in_byte;
  assign byte_ready = !queue_full;
  assign push       = byte_valid && !queue_full;
  assign stat       = '{phase: phase, carry: carry};

  always_comb begin
    job        = '0;
    job.eom    = byte_beat.is_last;
    phase_next = phase;
    carry_next = carry;
    case (phase)
      2'd1: begin
        job.slot[0].code = {carry[1:0], b[7:4]};
        carry_next       = b[3:0];
        phase_next       = 2'd2;
        if (byte_beat.is_last) begin
          job.slot[1].code = {b[3:0], 2'b00};
          job.slot[2].pad  = 1'b1;
          job.last_idx     = 2'd2;
        end
      end
      2'd2: begin
        job.slot[0].code = {carry, b[7:6]};
        job.slot[1].code = b[5:0];
        job.last_idx     = 2'd1;
        carry_next       = 4'd0;
        phase_next       = 2'd0;
      end
      default: begin
        // Start of a group; the unused phase code is treated the same way.
        job.slot[0].code = b[7:2];
        carry_next       = {2'b00, b[1:0]};
        phase_next       = 2'd1;
        if (byte_beat.is_last) begin
          job.slot[1].code = {b[1:0], 4'b0000};
          job.slot[2].pad  = 1'b1;
          job.slot[3].pad  = 1'b1;
          job.last_idx     = 2'd3;
        end
      end
    endcase
    if (byte_beat.is_last) begin
      phase_next = 2'd0;
      carry_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
      carry <= 4'd0;
    end else if (push) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

// ----- src/b64e_queue.sv -----
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of character jobs between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64e_pkg::job_t        wr_job,
  input  logic                  pop,
  output b64e_pkg::job_t        rd_job,
  output b64e_pkg::queue_stat_t stat
);
  import b64e_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            entry [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign stat.full  = (count == CntW'(QueueDepth));
  assign stat.empty = (count == '0);
  assign rd_job     = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/b64e_back.sv -----
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle, unless stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
  input  logic                clk,
  input  logic                rst,
  input  b64e_pkg::job_t      head,
  input  logic                head_empty,
  output logic                pop,
  output logic                char_valid,
  input  logic                char_ready,
  output b64e_pkg::out_beat_t char_beat
);
  import b64e_pkg::*;

  logic [1:0] idx;
  logic       load;
  slot_t      cur;

  assign cur  = head.slot[idx];
  assign load = !head_empty && (!char_valid || char_ready);
  assign pop  = load && (idx == head.last_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idx        <= 2'd0;
    end else begin
      if (load) begin
        char_valid <= 1'b1;
        idx        <= pop ? 2'd0 : idx + 2'd1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_beat.out_char <= cur.pad ? CHAR_PAD : b64_char(cur.code);
      char_beat.out_last <= head.eom && (idx == head.last_idx);
    end
  end

endmodule

// ----- src/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream in, standard-alphabet base64 characters out, with padding.
// ----------------------------------------------------------------------------
//
//   channel   handshake                   payload
//   -------   -------------------------   -----------------------------------
//   byte      byte_valid / byte_ready     byte_beat: in_byte, is_last
//   char      char_valid / char_ready     char_beat: out_char, out_last
//
// The front end takes one byte a cycle whenever the two-entry job queue has
// room. The back end sends one character a cycle unless stalled, so a byte
// yields one to four characters: four over a whole group of three bytes, four
// for a byte that closes a message at group start. Characters pass through the
// job queue and then the output register. Reset clears the group position,
// leftover bits, queue pointers and output valid; nothing else needs clearing.
// Each side stalls on its own: a stalled output holds its character while the
// queue keeps filling.
module base64_stream_encoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  b64e_pkg::in_beat_t  byte_beat,
  output logic                char_valid,
  input  logic                char_ready,
  output b64e_pkg::out_beat_t char_beat
);
  import b64e_pkg::*;

  logic        push;
  logic        pop;
  job_t        wr_job;
  job_t        head;
  queue_stat_t q_stat;
  front_stat_t f_stat;

  // The front end classifies each byte by its place in the three-byte group
  // and turns it into a job of six-bit codes and pad marks.
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .queue_full (q_stat.full),
    .push       (push),
    .job        (wr_job),
    .stat       (f_stat)
  );

  // The queue decouples byte acceptance from character delivery.
  b64e_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (head),
    .stat   (q_stat)
  );

  // The back end maps one code per cycle to ASCII unless stalled, and registers the beat.
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (q_stat.empty),
    .pop        (pop),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_beat  (char_beat)
  );

`include "base64_stream_encoder_assert.svh"

  // A message end always returns the front end to the start of a group.
  `B64E_ASSERT_NEXT(a_last_clears, byte_valid && byte_ready && byte_beat.is_last, f_stat.phase == 2'd0 && f_stat.carry == 4'd0)
  // The unused phase code never arises.
  `B64E_ASSERT_NOW(a_phase_range, 1'b1, f_stat.phase != 2'd3)
  // The front end only holds off when the queue is full.
  `B64E_ASSERT_NOW(a_ready_full, !byte_ready, q_stat.full)
  // A pad that does not end the message is followed by the closing pad.
  `B64E_ASSERT_NEXT(a_pad_pair, char_valid && char_beat.out_char == CHAR_PAD && !char_beat.out_last, char_valid && char_beat.out_char == CHAR_PAD)

endmodule
